FILE: design/tce_pkg.sv
package tce_pkg;

  // field widths
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 4;
  localparam int ATTR_W     = 2 * COLOR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COLOR_W;

  // default screen geometry
  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;

  // step modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  // reset values
  localparam logic [COLOR_W-1:0] RESET_FG   = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_BG   = 4'd0;
  localparam logic [CELL_W-1:0]  RESET_CELL = 16'h0720;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  target_row;
    logic [COL_W-1:0]  target_col;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic              cell_written;
    logic [POS_W-1:0]  cell_index;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } res_t;

endpackage

FILE: design/tce_in_if.sv
interface tce_in_if;
  logic                         valid;
  logic                         ready;
  logic [tce_pkg::MODE_W-1:0]   mode;
  logic [tce_pkg::CHAR_W-1:0]   char_code;
  logic [tce_pkg::ROW_W-1:0]    target_row;
  logic [tce_pkg::COL_W-1:0]    target_col;

  modport source (output valid, mode, char_code, target_row, target_col, input ready);
  modport sink (input valid, mode, char_code, target_row, target_col, output ready);
endinterface

FILE: design/tce_out_if.sv
interface tce_out_if;
  logic                         valid;
  logic                         ready;
  logic [tce_pkg::POS_W-1:0]    cursor_pos;
  logic                         cell_written;
  logic [tce_pkg::POS_W-1:0]    cell_index;
  logic [tce_pkg::CELL_W-1:0]   cell_value;
  logic                         scrolled;

  modport source (output valid, cursor_pos, cell_written, cell_index, cell_value, scrolled,
                  input ready);
  modport sink (input valid, cursor_pos, cell_written, cell_index, cell_value, scrolled,
                output ready);
endinterface

FILE: design/tce_cell_mem.sv
module tce_cell_mem #(
  parameter int DEPTH  = tce_pkg::DEF_SCREEN_COLS * tce_pkg::DEF_SCREEN_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tce_pkg::CELL_W-1:0]  wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tce_pkg::CELL_W-1:0]  rdata
);

  logic [tce_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tce_pkg::CELL_W-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/tce_seq.sv
module tce_seq #(
  parameter int SCREEN_COLS = tce_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tce_pkg::DEF_SCREEN_ROWS,
  parameter int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS,
  parameter int ADDR_W      = $clog2(CELL_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tce_pkg::ATTR_W-1:0]  attr,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  tce_pkg::cmd_t               cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tce_pkg::res_t               res,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [tce_pkg::CELL_W-1:0]  mem_wdata,
  output logic [ADDR_W-1:0]           mem_raddr,
  input  logic [tce_pkg::CELL_W-1:0]  mem_rdata
);

  localparam int ROW_W  = tce_pkg::ROW_W;
  localparam int COL_W  = tce_pkg::COL_W;
  localparam int POS_W  = tce_pkg::POS_W;
  localparam int RW1    = ROW_W + 1;
  localparam int CW1    = COL_W + 1;
  localparam int CALC_W = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  localparam logic [RW1-1:0]   ROWS_X    = RW1'(SCREEN_ROWS);
  localparam logic [CW1-1:0]   COLS_X    = CW1'(SCREEN_COLS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(SCREEN_COLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] MOVE_END = ADDR_W'(CELL_COUNT - SCREEN_COLS);
  localparam logic [ADDR_W-1:0] CELL_END = ADDR_W'(CELL_COUNT - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]        state_r;
  logic              init_r;
  logic              pend_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] waddr_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  tce_pkg::cmd_t     cmd_r;
  tce_pkg::res_t     res_r;

  logic [RW1-1:0]    row_inc;
  logic [CW1-1:0]    col_inc;
  logic [CW1-1:0]    col_tab;
  logic [RW1-1:0]    row_w;
  logic [CW1-1:0]    col_w;
  logic [ROW_W-1:0]  row_clamp;
  logic [COL_W-1:0]  col_clamp;
  logic [ROW_W-1:0]  row_fin;
  logic [COL_W-1:0]  col_fin;
  logic [CALC_W-1:0] idx_cur;
  logic [CALC_W-1:0] idx_rd;
  logic [CALC_W-1:0] pos_full;
  logic              put_wr;
  logic              do_scroll;
  logic              fast_done;
  logic [tce_pkg::CELL_W-1:0] put_cell;
  logic [tce_pkg::CELL_W-1:0] fill_cell;
  tce_pkg::res_t     res_c;

  // step decode and cursor update
  always_comb begin
    row_inc   = {1'b0, row_r} + RW1'(1);
    col_inc   = {1'b0, col_r} + CW1'(1);
    col_tab   = ({1'b0, col_r} + CW1'(4)) & ~CW1'(3);
    row_clamp = ({1'b0, cmd_r.target_row} >= ROWS_X) ? LAST_ROW : cmd_r.target_row;
    col_clamp = ({1'b0, cmd_r.target_col} >= COLS_X) ? LAST_COL : cmd_r.target_col;
    idx_cur   = CALC_W'(row_r) * CALC_W'(SCREEN_COLS) + CALC_W'(col_r);
    idx_rd    = CALC_W'(row_clamp) * CALC_W'(SCREEN_COLS) + CALC_W'(col_clamp);
    put_cell  = {attr, cmd_r.char_code};
    put_wr    = 1'b0;
    do_scroll = 1'b0;
    row_w     = {1'b0, row_r};
    col_w     = {1'b0, col_r};
    row_fin   = row_r;
    col_fin   = col_r;
    case (cmd_r.mode)
      tce_pkg::MODE_PUT: begin
        case (cmd_r.char_code)
          tce_pkg::CH_NL: begin
            row_w = row_inc;
            col_w = '0;
          end
          tce_pkg::CH_CR: begin
            col_w = '0;
          end
          tce_pkg::CH_TAB: begin
            if (col_tab >= COLS_X) begin
              row_w = row_inc;
              col_w = '0;
            end else begin
              col_w = col_tab;
            end
          end
          default: begin
            if (cmd_r.char_code >= tce_pkg::CH_SPACE) begin
              put_wr = 1'b1;
              if (col_inc >= COLS_X) begin
                row_w = row_inc;
                col_w = '0;
              end else begin
                col_w = col_inc;
              end
            end
          end
        endcase
        do_scroll = (row_w >= ROWS_X);
        row_fin   = do_scroll ? LAST_ROW : row_w[ROW_W-1:0];
        col_fin   = col_w[COL_W-1:0];
      end
      tce_pkg::MODE_CLEAR: begin
        row_fin = '0;
        col_fin = '0;
      end
      tce_pkg::MODE_MOVE: begin
        row_fin = row_clamp;
        col_fin = col_clamp;
      end
      default: begin
        row_fin = row_r;
        col_fin = col_r;
      end
    endcase
    pos_full  = CALC_W'(row_fin) * CALC_W'(SCREEN_COLS) + CALC_W'(col_fin);
    fast_done = ((cmd_r.mode == tce_pkg::MODE_PUT) && !do_scroll) ||
                (cmd_r.mode == tce_pkg::MODE_MOVE);

    res_c.cursor_pos   = pos_full[POS_W-1:0];
    res_c.cell_written = put_wr;
    res_c.scrolled     = do_scroll;
    if (put_wr) begin
      res_c.cell_index = idx_cur[POS_W-1:0];
      res_c.cell_value = put_cell;
    end else if (cmd_r.mode == tce_pkg::MODE_READ) begin
      res_c.cell_index = idx_rd[POS_W-1:0];
      res_c.cell_value = '0;
    end else begin
      res_c.cell_index = '0;
      res_c.cell_value = '0;
    end
  end

  // memory port selection
  assign fill_cell = init_r ? tce_pkg::RESET_CELL : {attr, tce_pkg::CH_SPACE};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = fill_cell;
    case (state_r)
      ST_EXEC: begin
        mem_we    = put_wr;
        mem_waddr = idx_cur[ADDR_W-1:0];
        mem_wdata = put_cell;
      end
      ST_SCROLL: begin
        mem_we    = pend_r;
        mem_waddr = waddr_r;
        mem_wdata = mem_rdata;
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    mem_raddr = (state_r == ST_SCROLL) ? (cnt_r + COLS_A) : idx_rd[ADDR_W-1:0];
  end

  // handshakes
  assign cmd_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE) || ((state_r == ST_EXEC) && fast_done);
  assign res       = (state_r == ST_EXEC) ? res_c : res_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      init_r  <= 1'b1;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          row_r  <= row_fin;
          col_r  <= col_fin;
          cnt_r  <= '0;
          pend_r <= 1'b0;
          if (cmd_r.mode == tce_pkg::MODE_CLEAR) begin
            state_r <= ST_FILL;
          end else if (cmd_r.mode == tce_pkg::MODE_READ) begin
            state_r <= ST_READ;
          end else if (do_scroll) begin
            state_r <= ST_SCROLL;
          end else if (res_ready) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_READ: begin
          state_r <= ST_DONE;
        end
        ST_SCROLL: begin
          if (cnt_r != MOVE_END) begin
            pend_r <= 1'b1;
            cnt_r  <= cnt_r + ADDR_W'(1);
          end else begin
            pend_r  <= 1'b0;
            state_r <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (cnt_r == CELL_END) begin
            init_r  <= 1'b0;
            state_r <= init_r ? ST_IDLE : ST_DONE;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && cmd_valid) begin
      cmd_r <= cmd;
    end
    if (state_r == ST_EXEC) begin
      res_r <= res_c;
    end
    if (state_r == ST_READ) begin
      res_r.cell_value <= mem_rdata;
    end
    if (state_r == ST_SCROLL) begin
      waddr_r <= cnt_r;
    end
  end

endmodule

FILE: design/text_console_engine.sv
// Text console engine: a screen store of SCREEN_COLS x SCREEN_ROWS 16-bit cells
// (character low byte, attribute high byte) driven by one command per transfer.
// in_ch carries mode, char_code, target_row and target_col; out_ch returns one
// result per command: cursor_pos, cell_written, cell_index, cell_value, scrolled.
// cfg_we/cfg_index/cfg_data write the fg (index 0) and bg (index 1) colours;
// write them only while no command is in flight.
// Put without scroll and move return their result from the execute state, read
// passes through a read state, clear runs a fill sweep and a put that scrolls
// runs a copy sweep plus a bottom row fill. The sweeps go through the single
// write port of the cell memory, one cell per cycle. A new command is taken only
// when the sequencer is idle, so the sequencer works on one command at a time.
// After reset a clearing pass fills every cell with 0x0720; in_ch.ready stays
// low during it.
// Results sit in an output register; while the receiver stalls out_ch holds
// its payload and one more command may be taken and finished, after which the
// sequencer waits for the output register to free up.
module text_console_engine #(
  parameter int SCREEN_COLS = tce_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tce_pkg::DEF_SCREEN_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tce_in_if.sink                          in_ch,
  tce_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [tce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tce_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic [tce_pkg::COLOR_W-1:0] fg_r;
  logic [tce_pkg::COLOR_W-1:0] bg_r;
  logic                        out_valid_r;
  tce_pkg::res_t               out_res_r;

  tce_pkg::cmd_t               cmd;
  tce_pkg::res_t               res;
  logic                        cmd_ready;
  logic                        res_valid;
  logic                        res_ready;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tce_pkg::CELL_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [tce_pkg::CELL_W-1:0]  mem_rdata;

  // colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tce_pkg::RESET_FG;
      bg_r <= tce_pkg::RESET_BG;
    end else if (cfg_we) begin
      case (cfg_index)
        tce_pkg::CFG_FG: fg_r <= cfg_data;
        tce_pkg::CFG_BG: bg_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input transfer
  assign cmd.mode       = in_ch.mode;
  assign cmd.char_code  = in_ch.char_code;
  assign cmd.target_row = in_ch.target_row;
  assign cmd.target_col = in_ch.target_col;
  assign in_ch.ready    = cmd_ready;

  tce_seq #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .CELL_COUNT  (CELL_COUNT),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      ({bg_r, fg_r}),
    .cmd_valid (in_ch.valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tce_cell_mem #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cursor_pos   = out_res_r.cursor_pos;
  assign out_ch.cell_written = out_res_r.cell_written;
  assign out_ch.cell_index   = out_res_r.cell_index;
  assign out_ch.cell_value   = out_res_r.cell_value;
  assign out_ch.scrolled     = out_res_r.scrolled;

endmodule

FILE: design/tce_checker.sv
module tce_checker #(
  parameter int SCREEN_COLS = tce_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tce_pkg::DEF_SCREEN_ROWS
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tce_pkg::POS_W-1:0]   cursor_pos,
  input logic                        cell_written,
  input logic [tce_pkg::POS_W-1:0]   cell_index,
  input logic [tce_pkg::CELL_W-1:0]  cell_value,
  input logic                        scrolled
);

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;

  // stalled result keeps valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(cursor_pos) && $stable(cell_written) &&
      $stable(cell_index) && $stable(cell_value) && $stable(scrolled))
    else $error("result payload changed while stalled");

  // sequencer is busy right after taking a command
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while a step is in flight");

  // a put without scroll leaves the cursor just past the written cell
  a_put_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cell_written && !scrolled |->
      cursor_pos == tce_pkg::POS_W'(cell_index + tce_pkg::POS_W'(1)))
    else $error("cursor not advanced past written cell");

  // cursor stays on screen and written cells are printable
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CELL_COUNT > 2047) || (int'(cursor_pos) < CELL_COUNT) &&
      (!cell_written || (cell_value[7:0] >= tce_pkg::CH_SPACE)))
    else $error("cursor off screen or control byte written");

endmodule

bind text_console_engine tce_checker #(
  .SCREEN_COLS (SCREEN_COLS),
  .SCREEN_ROWS (SCREEN_ROWS)
) u_tce_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cursor_pos   (out_ch.cursor_pos),
  .cell_written (out_ch.cell_written),
  .cell_index   (out_ch.cell_index),
  .cell_value   (out_ch.cell_value),
  .scrolled     (out_ch.scrolled)
);
